>>> rtl/rpd_pkg.sv
// ----------------------------------------------------------------------------
// rpd_pkg: shared types and constants of the run-length packet decoder
// Holds the classified byte that the front stage hands to the back stage.
// ----------------------------------------------------------------------------
`default_nettype none

package rpd_pkg;

	// Largest number of pixels in one packet; the header's low seven bits plus one.
	localparam int unsigned MaxPacketPixels = 128;

	// Bytes per pixel that the decoder supports at most.
	localparam int unsigned MaxBytesPerPixel = 4;

	localparam int unsigned ByteW  = 8;
	localparam int unsigned PixelW = ByteW * MaxBytesPerPixel;
	localparam int unsigned CountW = 32;
	localparam int unsigned BppW   = 3;
	localparam int unsigned IdxW   = $clog2(MaxBytesPerPixel);
	localparam int unsigned LenW   = $clog2(MaxPacketPixels) + 1;

	// Configuration register indexes.
	typedef enum logic [0:0] {
		CFG_BYTES_PER_PIXEL = 1'b0,
		CFG_PIXEL_COUNT     = 1'b1
	} cfg_index_t;

	// One stream byte together with its meaning if it turns out to be a header.
	typedef struct packed {
		logic              run;   // header would start a run packet
		logic [LenW-1:0]   len;   // pixels the packet would hold
		logic [ByteW-1:0]  data;  // the raw byte
	} rpd_item_t;

endpackage

`default_nettype wire

>>> rtl/rpd_front.sv
// ----------------------------------------------------------------------------
// rpd_front: input stage of the run-length packet decoder
// Registers each stream byte and classifies it as a possible packet header.
// ----------------------------------------------------------------------------
`default_nettype none

module rpd_front (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      in_valid,
	output logic                           in_ready,
	input  wire logic [rpd_pkg::ByteW-1:0] stream_byte,
	output logic                           item_valid,
	input  wire logic                      item_ready,
	output rpd_pkg::rpd_item_t             item
);
	import rpd_pkg::*;

	logic      valid_s1;
	rpd_item_t item_s1;

	// The stage refills in the same cycle that the queue drains it.
	assign in_ready   = !valid_s1 || item_ready;
	assign item_valid = valid_s1;
	assign item       = item_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	// Both packet kinds hold the header's low seven bits plus one pixels.
	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			item_s1.data <= stream_byte;
			item_s1.run  <= stream_byte[ByteW-1];
			item_s1.len  <= LenW'({1'b0, stream_byte[ByteW-2:0]}) + LenW'(1);
		end
	end

endmodule

`default_nettype wire

>>> rtl/rpd_queue.sv
// ----------------------------------------------------------------------------
// rpd_queue: short queue between front and back of the packet decoder
// A small circular buffer of classified bytes with full and empty flags.
// ----------------------------------------------------------------------------
`default_nettype none

module rpd_queue #(
	parameter int unsigned DEPTH = 2
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               push_valid,
	output logic                    push_ready,
	input  wire rpd_pkg::rpd_item_t push_item,
	output logic                    pop_valid,
	input  wire logic               pop_ready,
	output rpd_pkg::rpd_item_t      pop_item
);
	import rpd_pkg::*;

	localparam int unsigned PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CntW = $clog2(DEPTH + 1);

	rpd_item_t           entries_q [DEPTH];
	logic [PtrW-1:0]     wr_ptr_q;
	logic [PtrW-1:0]     rd_ptr_q;
	logic [CntW-1:0]     fill_q;
	logic                push;
	logic                pop;

	assign push_ready = (fill_q != CntW'(DEPTH));
	assign pop_valid  = (fill_q != '0);
	assign pop_item   = entries_q[rd_ptr_q];
	assign push       = push_valid && push_ready;
	assign pop        = pop_valid && pop_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			fill_q   <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PtrW'(DEPTH - 1)) ? '0 : wr_ptr_q + PtrW'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PtrW'(DEPTH - 1)) ? '0 : rd_ptr_q + PtrW'(1);
			end
			if (push && !pop) begin
				fill_q <= fill_q + CntW'(1);
			end else if (pop && !push) begin
				fill_q <= fill_q - CntW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			entries_q[wr_ptr_q] <= push_item;
		end
	end

endmodule

`default_nettype wire

>>> rtl/rpd_back.sv
// ----------------------------------------------------------------------------
// rpd_back: packet decoding stage of the run-length packet decoder
// Tracks packets, assembles pixels, counts them against the image size and
// holds each result in an output register.
// ----------------------------------------------------------------------------
`default_nettype none

module rpd_back (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic [rpd_pkg::BppW-1:0]   bytes_per_pixel,
	input  wire logic [rpd_pkg::CountW-1:0] pixel_count,
	input  wire logic                       item_valid,
	output logic                            item_ready,
	input  wire rpd_pkg::rpd_item_t         item,
	output logic                            out_valid,
	input  wire logic                       out_ready,
	output logic [rpd_pkg::PixelW-1:0]      pixel_value,
	output logic [rpd_pkg::ByteW-1:0]       repeat_count,
	output logic                            image_done,
	output logic                            overflow_error
);
	import rpd_pkg::*;

	localparam int unsigned AsmW = PixelW - ByteW;

	// Decode state.
	logic                expect_header_q;
	logic                run_packet_q;
	logic [LenW-1:0]     left_q;
	logic [IdxW-1:0]     byte_index_q;
	logic [AsmW-1:0]     assembly_q;
	logic [CountW-1:0]   pixels_done_q;

	// Output register.
	logic                out_valid_q;
	logic [PixelW-1:0]   pixel_q;
	logic [ByteW-1:0]    repeat_q;
	logic                done_q;
	logic                err_q;

	logic                step;
	logic [IdxW-1:0]     last_index;
	logic                last_byte;
	logic [PixelW-1:0]   shifted;
	logic [PixelW-1:0]   pixel;
	logic [CountW:0]     diff;
	logic [CountW-1:0]   remaining;
	logic [LenW-1:0]     want;
	logic                want_lt_rem;
	logic [LenW-1:0]     count;
	logic                done;
	logic                err;
	logic [LenW-1:0]     left_next;
	logic                emit;

	assign item_ready = !out_valid_q || out_ready;
	assign step       = item_valid && item_ready;

	// Out-of-range pixel widths clamp: zero acts as one, above four acts as four.
	always_comb begin
		case (bytes_per_pixel) inside
			[3'd0:3'd1]: last_index = IdxW'(0);
			3'd2:        last_index = IdxW'(1);
			3'd3:        last_index = IdxW'(2);
			default:     last_index = IdxW'(3);
		endcase
	end

	// A byte index past the last one (pixel width lowered mid-pixel) also ends the pixel.
	assign last_byte = !(byte_index_q < last_index);
	assign shifted   = PixelW'(item.data) << {byte_index_q, 3'b000};
	assign pixel     = {{ByteW{1'b0}}, assembly_q} | shifted;

	// Pixels still owed to the image; nothing if the count was lowered below the progress.
	assign diff      = {1'b0, pixel_count} - {1'b0, pixels_done_q};
	assign remaining = diff[CountW] ? '0 : diff[CountW-1:0];

	assign want        = run_packet_q ? left_q : LenW'(1);
	assign want_lt_rem = (remaining[CountW-1:LenW] != '0) || (want < remaining[LenW-1:0]);
	assign count       = want_lt_rem ? want : remaining[LenW-1:0];
	assign done        = !want_lt_rem;
	assign err         = done && (left_q > count);
	assign left_next   = left_q - want;

	assign emit = step && !expect_header_q && last_byte;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			expect_header_q <= 1'b1;
			run_packet_q    <= 1'b0;
			left_q          <= '0;
			byte_index_q    <= '0;
			assembly_q      <= '0;
			pixels_done_q   <= '0;
			out_valid_q     <= 1'b0;
		end else begin
			if (emit) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end

			if (step) begin
				if (expect_header_q) begin
					run_packet_q    <= item.run;
					left_q          <= item.len;
					expect_header_q <= 1'b0;
					byte_index_q    <= '0;
					assembly_q      <= '0;
				end else if (!last_byte) begin
					assembly_q   <= assembly_q | shifted[AsmW-1:0];
					byte_index_q <= byte_index_q + IdxW'(1);
				end else begin
					byte_index_q <= '0;
					assembly_q   <= '0;
					if (done) begin
						// Image complete or clipped: start over on a new image.
						expect_header_q <= 1'b1;
						run_packet_q    <= 1'b0;
						left_q          <= '0;
						pixels_done_q   <= '0;
					end else begin
						pixels_done_q <= pixels_done_q + CountW'(count);
						left_q        <= left_next;
						if (left_next == '0) begin
							expect_header_q <= 1'b1;
						end
					end
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			pixel_q  <= pixel;
			repeat_q <= ByteW'(count);
			done_q   <= done;
			err_q    <= err;
		end
	end

	assign out_valid      = out_valid_q;
	assign pixel_value    = pixel_q;
	assign repeat_count   = repeat_q;
	assign image_done     = done_q;
	assign overflow_error = err_q;

endmodule

`default_nettype wire

>>> rtl/rle_packet_decoder_unit.sv
// ----------------------------------------------------------------------------
// rle_packet_decoder_unit: run-length packet decoder for TGA pixel streams
// Turns the compressed byte stream into pixels with repeat counts.
// ----------------------------------------------------------------------------
// The compressed stream enters one byte per transfer on in_valid/in_ready.
// A header byte below 128 opens a raw packet of header+1 literal pixels; any
// other header opens a run of header-127 copies of one pixel. Each pixel is
// built from bytes_per_pixel bytes, first byte lowest, and leaves as one
// transfer on out_valid/out_ready: one per raw pixel with repeat_count 1,
// one per run with the whole count. Header bytes and the inner bytes of a
// pixel produce no result. The transfer that reaches pixel_count carries
// image_done; a packet that passes it is clipped and also flags
// overflow_error. The next byte then starts a new image.
// Throughput is one byte per clock. The result of the byte that completes a
// pixel passes the input register, the queue and the output register. A
// stalled receiver holds the output register; the queue keeps the input
// side flowing until it fills, then in_ready drops. Reset clears the decode
// state and sets bytes_per_pixel to 4 and pixel_count to 1. Registers are
// written through cfg_write_en while idle; only the user enforces that.
// ----------------------------------------------------------------------------
`default_nettype none

module rle_packet_decoder_unit #(
	parameter int unsigned QUEUE_DEPTH = 2
) (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	// configuration write port
	input  wire logic                       cfg_write_en,
	input  wire logic [0:0]                 cfg_index,
	input  wire logic [rpd_pkg::CountW-1:0] cfg_data,
	// compressed byte stream
	input  wire logic                       in_valid,
	output logic                            in_ready,
	input  wire logic [rpd_pkg::ByteW-1:0]  stream_byte,
	// decoded pixels
	output logic                            out_valid,
	input  wire logic                       out_ready,
	output logic [rpd_pkg::PixelW-1:0]      pixel_value,
	output logic [rpd_pkg::ByteW-1:0]       repeat_count,
	output logic                            image_done,
	output logic                            overflow_error
);
	import rpd_pkg::*;

	logic [BppW-1:0]   bytes_per_pixel_q;
	logic [CountW-1:0] pixel_count_q;

	logic              front_valid;
	logic              front_ready;
	rpd_item_t         front_item;
	logic              back_valid;
	logic              back_ready;
	rpd_item_t         back_item;

	// Configuration registers. Writes leave the decode state untouched.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bytes_per_pixel_q <= BppW'(MaxBytesPerPixel);
			pixel_count_q     <= CountW'(1);
		end else if (cfg_write_en) begin
			case (cfg_index_t'(cfg_index))
				CFG_BYTES_PER_PIXEL: bytes_per_pixel_q <= cfg_data[BppW-1:0];
				CFG_PIXEL_COUNT:     pixel_count_q     <= cfg_data;
				default: ;
			endcase
		end
	end

	// Front: registers each byte and classifies it as a potential header.
	rpd_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.stream_byte (stream_byte),
		.item_valid  (front_valid),
		.item_ready  (front_ready),
		.item        (front_item)
	);

	// Queue decouples the front from output back-pressure.
	rpd_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (front_valid),
		.push_ready (front_ready),
		.push_item  (front_item),
		.pop_valid  (back_valid),
		.pop_ready  (back_ready),
		.pop_item   (back_item)
	);

	// Back: packet tracking, pixel assembly, image counting and the output register.
	rpd_back u_back (
		.clk             (clk),
		.arst_n          (arst_n),
		.bytes_per_pixel (bytes_per_pixel_q),
		.pixel_count     (pixel_count_q),
		.item_valid      (back_valid),
		.item_ready      (back_ready),
		.item            (back_item),
		.out_valid       (out_valid),
		.out_ready       (out_ready),
		.pixel_value     (pixel_value),
		.repeat_count    (repeat_count),
		.image_done      (image_done),
		.overflow_error  (overflow_error)
	);

endmodule

`default_nettype wire

>>> tb/sv/tb_rle_packet_decoder_unit.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_rle_packet_decoder_unit: self-checking bench for the RLE packet decoder
// Streams compressed packet bytes into the decoder under several register
// settings and handshake pressures. A scoreboard predicts every pixel
// transfer and compares each output transfer with the oldest prediction.
// ----------------------------------------------------------------------------

module tb_rle_packet_decoder_unit;
	import rpd_pkg::*;

	// Number of stream bytes in the random part of the run.
	localparam int RandomBytes = 1200;
	// Idle cycles before a register write once every pixel has come out. The
	// decoder passes each byte through its input register and queue, so this
	// comfortably covers bytes still in flight that give no result.
	localparam int SettleCycles = 10;

	// One predicted or observed pixel transfer.
	typedef struct packed {
		logic [PixelW-1:0] pixel;
		logic [ByteW-1:0]  count;
		logic              done;
		logic              clipped;
	} pixel_result_t;

	typedef logic [ByteW-1:0] byte_q_t[$];

	// The scoreboard carries its own copy of the decode state and of the two
	// registers, decodes every accepted byte, and queues the pixels it expects.
	class pixel_scoreboard;
		pixel_result_t pending_pixels[$];

		logic [BppW-1:0]   width_reg;
		logic [CountW-1:0] count_reg;

		bit                header_next;
		bit                run_mode;
		logic [ByteW-1:0]  packet_left;
		logic [IdxW-1:0]   byte_pos;
		logic [23:0]       assembly;
		logic [CountW-1:0] pixels_placed;

		int errors;
		int bytes_in;
		int pixels_out;
		int images_ended;
		int images_clipped;
		logic [7:0] widths_used;

		function new();
			width_reg = 3'd4;
			count_reg = 32'd1;
			widths_used = '0;
			start_image();
		endfunction

		function void start_image();
			header_next = 1'b1;
			run_mode = 1'b0;
			packet_left = '0;
			byte_pos = '0;
			assembly = '0;
			pixels_placed = '0;
		endfunction

		// Register writes leave the decode state alone.
		function void write_reg(cfg_index_t index, logic [CountW-1:0] value);
			if (index == CFG_BYTES_PER_PIXEL) begin
				width_reg = value[BppW-1:0];
				widths_used[value[BppW-1:0]] = 1'b1;
			end else begin
				count_reg = value;
			end
		endfunction

		function int pending();
			return pending_pixels.size();
		endfunction

		// Decodes one accepted stream byte and queues the pixel it completes.
		function void note_byte(logic [ByteW-1:0] b);
			int unsigned eff;
			logic [31:0] placed;
			logic [31:0] remaining;
			logic [31:0] want;
			logic [31:0] cnt;
			pixel_result_t res;

			bytes_in++;
			// Widths of zero behave as one byte, widths above four as four.
			if (width_reg == 0)
				eff = 1;
			else if (width_reg > MaxBytesPerPixel)
				eff = MaxBytesPerPixel;
			else
				eff = 32'(width_reg);

			if (header_next) begin
				run_mode = (b >= MaxPacketPixels);
				packet_left = run_mode ? ByteW'(b - (MaxPacketPixels - 1)) : ByteW'(b + 1);
				header_next = 1'b0;
				byte_pos = '0;
				assembly = '0;
				return;
			end

			placed = 32'(b) << (8 * byte_pos);
			// A width lowered in the middle of a pixel lets this byte finish it.
			if (byte_pos + 1 < eff) begin
				assembly = assembly | placed[23:0];
				byte_pos = byte_pos + 1'b1;
				return;
			end

			res.pixel = {8'b0, assembly} | placed;
			byte_pos = '0;
			assembly = '0;

			remaining = (count_reg > pixels_placed) ? count_reg - pixels_placed : 32'd0;
			want = run_mode ? 32'(packet_left) : 32'd1;
			cnt = (want < remaining) ? want : remaining;
			res.count = cnt[ByteW-1:0];
			res.done = (cnt == remaining);
			res.clipped = res.done && (32'(packet_left) > cnt);
			pending_pixels.push_back(res);

			if (res.done) begin
				// The rest of a clipped packet is dropped; a new image begins.
				start_image();
			end else begin
				pixels_placed = pixels_placed + cnt;
				packet_left = packet_left - want[ByteW-1:0];
				if (packet_left == 0)
					header_next = 1'b1;
			end
		endfunction

		// Compares one output transfer with the oldest predicted pixel.
		function void check_pixel(pixel_result_t got);
			pixel_result_t exp_res;

			if (pending_pixels.size() == 0) begin
				$error("pixel transfer with nothing predicted: pixel_value %h", got.pixel);
				errors++;
				return;
			end
			exp_res = pending_pixels.pop_front();
			pixels_out++;
			if (exp_res.done)
				images_ended++;
			if (exp_res.clipped)
				images_clipped++;
			if (got.pixel !== exp_res.pixel) begin
				$error("pixel_value: expected %h, actual %h", exp_res.pixel, got.pixel);
				errors++;
			end
			if (got.count !== exp_res.count) begin
				$error("repeat_count: expected %0d, actual %0d", exp_res.count, got.count);
				errors++;
			end
			if (got.done !== exp_res.done) begin
				$error("image_done: expected %b, actual %b", exp_res.done, got.done);
				errors++;
			end
			if (got.clipped !== exp_res.clipped) begin
				$error("overflow_error: expected %b, actual %b", exp_res.clipped, got.clipped);
				errors++;
			end
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	logic              cfg_write_en = 1'b0;
	logic [0:0]        cfg_index = CFG_BYTES_PER_PIXEL;
	logic [CountW-1:0] cfg_data = '0;

	logic             in_valid = 1'b0;
	logic             in_ready;
	logic [ByteW-1:0] stream_byte = '0;

	logic              out_valid;
	logic              out_ready = 1'b0;
	logic [PixelW-1:0] pixel_value;
	logic [ByteW-1:0]  repeat_count;
	logic              image_done;
	logic              overflow_error;

	// Percent chances of a sender gap and of a receiver stall in each cycle.
	int send_idle_pct = 0;
	int recv_stall_pct = 0;

	pixel_scoreboard sb;

	rle_packet_decoder_unit u_top (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_write_en   (cfg_write_en),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.stream_byte    (stream_byte),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.pixel_value    (pixel_value),
		.repeat_count   (repeat_count),
		.image_done     (image_done),
		.overflow_error (overflow_error)
	);

	always #5 clk = ~clk;

	// The receiver decides anew every cycle whether to take a pixel.
	always @(posedge clk) begin
		out_ready <= ($urandom_range(99) >= recv_stall_pct);
	end

	// Output transfers are sampled at the edge, before any of this edge's updates
	// land. Input transfers are noted by the sending task itself, so the decode
	// state it reads for the next byte is always current.
	always @(posedge clk) begin
		if (arst_n) begin
			if (out_valid && out_ready)
				sb.check_pixel({pixel_value, repeat_count, image_done, overflow_error});
		end
	end

	// Offers one byte, possibly after a random gap, and returns at the edge
	// where the transfer takes place. Valid stays high while it waits for in_ready.
	task automatic send_byte(input logic [ByteW-1:0] b);
		if ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
		end
		in_valid <= 1'b1;
		stream_byte <= b;
		do @(posedge clk); while (!in_ready);
		sb.note_byte(b);
	endtask

	task automatic send_seq(input byte_q_t seq);
		foreach (seq[i])
			send_byte(seq[i]);
	endtask

	// Holds the sender off until every predicted pixel has come out. Always
	// waits on the clock so valid is never lowered and raised at once.
	task automatic drain_pixels();
		in_valid <= 1'b0;
		do @(posedge clk); while (sb.pending() != 0);
	endtask

	// Brings the decoder to rest before a register write.
	task automatic settle();
		drain_pixels();
		repeat (SettleCycles) @(posedge clk);
	endtask

	task automatic write_reg(input cfg_index_t index, input logic [CountW-1:0] value);
		cfg_write_en <= 1'b1;
		cfg_index <= index;
		cfg_data <= value;
		@(posedge clk);
		sb.write_reg(index, value);
		cfg_write_en <= 1'b0;
		@(posedge clk);
	endtask

	// Random byte: where a header is due, small packets are favored half the
	// time so that images close often and runs hit the count boundary.
	function automatic logic [ByteW-1:0] pick_byte(input bit header);
		if (header && $urandom_range(1) == 1) begin
			if ($urandom_range(1) == 1)
				return ByteW'($urandom_range(3));
			return ByteW'(MaxPacketPixels + $urandom_range(7));
		end
		return ByteW'($urandom_range(255));
	endfunction

	// Hard stop in case the decoder hangs or loses a pixel.
	initial begin
		#5_000_000;
		$display("TEST FAILED");
		$finish;
	end

	initial begin
		byte_q_t seq;
		int sent;
		int phase;
		int len;
		int k;
		int r;
		logic [BppW-1:0]   width;
		logic [CountW-1:0] total;

		sb = new();
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part. A raw pixel with all bits set, then a full run of 128
		// that overflows the two pixels left, so it is clipped and ends the image.
		write_reg(CFG_BYTES_PER_PIXEL, 32'd4);
		write_reg(CFG_PIXEL_COUNT, 32'd3);
		seq = '{8'h00, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'h00, 8'h80, 8'h7F, 8'h01};
		send_seq(seq);
		settle();

		// Width zero acts as one byte: a run of one, then the largest raw
		// packet clipped to the single pixel left.
		write_reg(CFG_BYTES_PER_PIXEL, 32'd0);
		write_reg(CFG_PIXEL_COUNT, 32'd2);
		seq = '{8'h80, 8'h5A, 8'h7F, 8'h01};
		send_seq(seq);
		settle();

		// With nothing left to place, the first pixel carries a zero count.
		write_reg(CFG_PIXEL_COUNT, 32'd0);
		seq = '{8'h81, 8'hA5};
		send_seq(seq);
		settle();

		// Width seven acts as four. The width drops to two after three bytes of
		// a pixel, so the fourth byte completes it in the top byte lane.
		write_reg(CFG_BYTES_PER_PIXEL, 32'd7);
		write_reg(CFG_PIXEL_COUNT, 32'hFFFF_FFFF);
		seq = '{8'h01, 8'h11, 8'h22, 8'h33};
		send_seq(seq);
		settle();
		write_reg(CFG_BYTES_PER_PIXEL, 32'd2);
		seq = '{8'h44, 8'hC3, 8'h3C};
		send_seq(seq);
		settle();

		// Count lowered to exactly the pixels already placed.
		write_reg(CFG_PIXEL_COUNT, 32'd2);
		seq = '{8'h00, 8'h5A, 8'hA5};
		send_seq(seq);
		settle();

		// Random part: each phase picks new register values and an idling
		// pattern, cycling through no idling, a sluggish sender, a sluggish
		// receiver, and light idling on both sides.
		sent = 0;
		phase = 0;
		while (sent < RandomBytes) begin
			case (phase % 4)
				0: begin
					send_idle_pct = 0;
					recv_stall_pct = 0;
				end
				1: begin
					send_idle_pct = 87;
					recv_stall_pct = 0;
				end
				2: begin
					send_idle_pct = 0;
					recv_stall_pct = 87;
				end
				default: begin
					send_idle_pct = 8;
					recv_stall_pct = 8;
				end
			endcase

			if ($urandom_range(9) < 7)
				width = BppW'($urandom_range(1, MaxBytesPerPixel));
			else
				width = BppW'($urandom_range(7));
			r = $urandom_range(19);
			if (r == 0)
				total = 32'd0;
			else if (r == 1)
				total = 32'd4294836225;
			else if (r == 2)
				total = 32'hFFFF_FFFF;
			else if (r == 3)
				total = $urandom;
			else if (r < 7)
				total = $urandom_range(1, 3);
			else
				total = $urandom_range(4, 400);
			write_reg(CFG_BYTES_PER_PIXEL, 32'(width));
			write_reg(CFG_PIXEL_COUNT, total);

			len = $urandom_range(60, 180);
			for (k = 0; k < len; k++) begin
				// Now and then the sender waits until every predicted pixel has come out.
				if ($urandom_range(149) == 0 || (phase == 1 && k == 40))
					drain_pixels();
				send_byte(pick_byte(sb.header_next));
				sent++;
			end
			settle();
			phase++;
		end

		$display("Decoded %0d stream bytes into %0d pixel transfers; %0d images ended, %0d clipped.",
			sb.bytes_in, sb.pixels_out, sb.images_ended, sb.images_clipped);
		$display("Ran %0d random phases; pixel widths written (bit per value): %b.",
			phase, sb.widths_used);
		if (sb.errors == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule
